/* rtl/kdsf_pkg.sv */
// Shared types, codes and constants for the kinetic drag-scroll controller.
package kdsf_pkg;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 72;
    localparam int CMD_W      = 2;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register index carried in paddr[2]
    localparam logic REG_DECEL_STEP  = 1'b0;
    localparam logic REG_SPEED_LIMIT = 1'b1;

    localparam logic [7:0]  DECEL_STEP_RST  = 8'd1;
    localparam logic [14:0] SPEED_LIMIT_RST = 15'd64;

    typedef enum logic [CMD_W-1:0] {
        CMD_PRESS   = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_MOVE    = 2'd2,
        CMD_TICK    = 2'd3
    } t_cmd;

    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_PRESSED = 5'b00010,
        MODE_DRAG    = 5'b00100,
        MODE_COAST   = 5'b01000,
        MODE_STOP    = 5'b10000
    } t_mode;

    localparam logic [2:0] CODE_IDLE    = 3'd0;
    localparam logic [2:0] CODE_PRESSED = 3'd1;
    localparam logic [2:0] CODE_DRAG    = 3'd2;
    localparam logic [2:0] CODE_COAST   = 3'd3;
    localparam logic [2:0] CODE_STOP    = 3'd4;

    typedef struct packed {
        logic [7:0]  decel_step;
        logic [14:0] speed_limit;
    } t_cfg;

    typedef struct packed {
        t_cmd               cmd;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic               left_only;
    } t_item;

    typedef struct packed {
        t_mode              mode;
        logic signed [15:0] press_x;
        logic signed [15:0] press_y;
        logic [31:0]        grab_x;
        logic [31:0]        grab_y;
        logic signed [15:0] drag_x;
        logic signed [15:0] drag_y;
        logic signed [16:0] speed_x;
        logic signed [16:0] speed_y;
        logic [31:0]        page_x;
        logic [31:0]        page_y;
    } t_state;

    function automatic logic [2:0] mode_code(input t_mode m);
        logic [2:0] c;
        case (m)
            MODE_IDLE:    c = CODE_IDLE;
            MODE_PRESSED: c = CODE_PRESSED;
            MODE_DRAG:    c = CODE_DRAG;
            MODE_COAST:   c = CODE_COAST;
            MODE_STOP:    c = CODE_STOP;
            default:      c = CODE_IDLE;
        endcase
        return c;
    endfunction

endpackage

/* rtl/kinetic_drag_scroll_fsm.sv */
// Top level of the kinetic drag-scroll controller: stream ports, pipeline, state.
// Path: an accepted beat is held in the input register, then in the result register.
// Throughput: one beat per cycle while i_m_tready holds high; the mode and scroll
// state registers loop through next-state logic in kdsf_core, combinational only.
// Reset: synchronous, active low; mode goes idle, all positions and speeds to zero,
// decel_step to 1 and speed_limit to 64; both pipeline stages empty.
module kinetic_drag_scroll_fsm (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input stream
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // [15:0] pos_x, [31:16] pos_y, [32] left_only, [39:33] zero
    input  logic [kdsf_pkg::IN_DATA_W-1:0]       i_s_tdata,
    // [1:0] command
    input  logic [kdsf_pkg::CMD_W-1:0]           i_s_tuser,
    // result stream
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // [0] consumed, [1] scroll_written, [33:2] view_x, [65:34] view_y,
    // [68:66] mode_now, [71:69] zero
    output logic [kdsf_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    // configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [kdsf_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [kdsf_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [kdsf_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);

    kdsf_pkg::t_cfg   cfg;
    kdsf_pkg::t_item  r_in;
    logic             r_in_valid;
    kdsf_pkg::t_state r_state;
    kdsf_pkg::t_state n_state;
    logic             n_consumed;
    logic             n_written;
    logic             r_out_valid;
    logic [kdsf_pkg::OUT_DATA_W-1:0] r_out_data;
    logic             s_take;      // input beat taken into stage 1
    logic             step_fire;   // stage 1 item applied to state and result reg

    kdsf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    kdsf_core u_core (
        .i_item     (r_in),
        .i_state    (r_state),
        .i_cfg      (cfg),
        .o_state    (n_state),
        .o_consumed (n_consumed),
        .o_written  (n_written)
    );

    // result reg frees up when it is empty or its beat leaves this cycle
    assign step_fire  = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || step_fire;
    assign s_take     = i_s_tvalid && o_s_tready;

    // stage 1: input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_in.cmd       <= kdsf_pkg::t_cmd'(i_s_tuser);
            r_in.pos_x     <= i_s_tdata[15:0];
            r_in.pos_y     <= i_s_tdata[31:16];
            r_in.left_only <= i_s_tdata[32];
        end
    end

    // architectural state, updated once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode    <= kdsf_pkg::MODE_IDLE;
            r_state.press_x <= '0;
            r_state.press_y <= '0;
            r_state.grab_x  <= '0;
            r_state.grab_y  <= '0;
            r_state.drag_x  <= '0;
            r_state.drag_y  <= '0;
            r_state.speed_x <= '0;
            r_state.speed_y <= '0;
            r_state.page_x  <= '0;
            r_state.page_y  <= '0;
        end else if (step_fire) begin
            r_state <= n_state;
        end
    end

    // stage 2: result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_fire) begin
            r_out_data <= {3'b000, kdsf_pkg::mode_code(n_state.mode),
                           n_state.page_y, n_state.page_x, n_written, n_consumed};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

`ifndef SYNTHESIS
    // scroll only moves on items that report a write
    a_page_only_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_fire && !n_written |-> (n_state.page_x == r_state.page_x)
                                    && (n_state.page_y == r_state.page_y))
        else $error("scroll changed without scroll_written");

    // ticks are never swallowed
    a_tick_not_consumed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_fire && (r_in.cmd == kdsf_pkg::CMD_TICK) |-> !n_consumed)
        else $error("tick reported as consumed");

    // an accepted input beat always lands in stage 1
    a_in_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_take |=> r_in_valid)
        else $error("accepted beat lost before stage 1");

    // a coasting tick leaves each speed within the clamp limit
    a_coast_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_fire && (r_in.cmd == kdsf_pkg::CMD_TICK)
        && (r_state.mode == kdsf_pkg::MODE_COAST)
        |-> ($signed({n_state.speed_x[16], n_state.speed_x})
                <= $signed({3'b000, cfg.speed_limit}))
            && ($signed({n_state.speed_x[16], n_state.speed_x})
                >= -$signed({3'b000, cfg.speed_limit}))
            && ($signed({n_state.speed_y[16], n_state.speed_y})
                <= $signed({3'b000, cfg.speed_limit}))
            && ($signed({n_state.speed_y[16], n_state.speed_y})
                >= -$signed({3'b000, cfg.speed_limit})))
        else $error("coast speed exceeds limit");
`endif

endmodule

/* rtl/kdsf_decay.sv */
// Speed component clamp and decay toward zero for one coasting tick.
module kdsf_decay (
    input  logic signed [16:0] i_speed,
    input  kdsf_pkg::t_cfg     i_cfg,
    output logic signed [16:0] o_speed
);

    logic signed [17:0] v;
    logic signed [17:0] lim;
    logic signed [17:0] step;
    logic signed [17:0] clamped;
    logic signed [17:0] dec;

    always_comb begin
        v    = {i_speed[16], i_speed};
        lim  = signed'({3'b000, i_cfg.speed_limit});
        step = signed'({10'b0, i_cfg.decel_step});
        if (v > lim) begin
            clamped = lim;
        end else if (v < -lim) begin
            clamped = -lim;
        end else begin
            clamped = v;
        end
        if (clamped > 18'sd0) begin
            dec = clamped - step;
            if (dec < 18'sd0) dec = '0;
        end else if (clamped < 18'sd0) begin
            dec = clamped + step;
            if (dec > 18'sd0) dec = '0;
        end else begin
            dec = '0;
        end
        o_speed = dec[16:0];
    end

endmodule

/* rtl/kdsf_cfg.sv */
// APB register file: decel step and speed limit.
module kdsf_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [kdsf_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [kdsf_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [kdsf_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output kdsf_pkg::t_cfg                      o_cfg
);

    kdsf_pkg::t_cfg r_cfg;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.decel_step  <= kdsf_pkg::DECEL_STEP_RST;
            r_cfg.speed_limit <= kdsf_pkg::SPEED_LIMIT_RST;
        end else if (wr_en) begin
            if (paddr[2] == kdsf_pkg::REG_DECEL_STEP) begin
                r_cfg.decel_step <= pwdata[7:0];
            end else begin
                r_cfg.speed_limit <= pwdata[14:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == kdsf_pkg::REG_SPEED_LIMIT) begin
            prdata = {17'b0, r_cfg.speed_limit};
        end else begin
            prdata = {24'b0, r_cfg.decel_step};
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/kdsf_core.sv */
// Next-state and result logic for one item of the drag-scroll controller.
module kdsf_core (
    input  kdsf_pkg::t_item  i_item,
    input  kdsf_pkg::t_state i_state,
    input  kdsf_pkg::t_cfg   i_cfg,
    output kdsf_pkg::t_state o_state,
    output logic             o_consumed,
    output logic             o_written
);

    logic signed [16:0] dec_x;
    logic signed [16:0] dec_y;
    logic signed [16:0] trav_x;
    logic signed [16:0] trav_y;
    logic signed [16:0] tick_sx;
    logic signed [16:0] tick_sy;
    logic               at_press;

    kdsf_decay u_decay_x (.i_speed(i_state.speed_x), .i_cfg(i_cfg), .o_speed(dec_x));
    kdsf_decay u_decay_y (.i_speed(i_state.speed_y), .i_cfg(i_cfg), .o_speed(dec_y));

    assign trav_x   = {i_item.pos_x[15], i_item.pos_x} - {i_state.press_x[15], i_state.press_x};
    assign trav_y   = {i_item.pos_y[15], i_item.pos_y} - {i_state.press_y[15], i_state.press_y};
    assign tick_sx  = {i_item.pos_x[15], i_item.pos_x} - {i_state.drag_x[15], i_state.drag_x};
    assign tick_sy  = {i_item.pos_y[15], i_item.pos_y} - {i_state.drag_y[15], i_state.drag_y};
    assign at_press = (i_item.pos_x == i_state.press_x) && (i_item.pos_y == i_state.press_y);

    always_comb begin
        o_state    = i_state;
        o_consumed = 1'b0;
        o_written  = 1'b0;
        if (i_item.cmd == kdsf_pkg::CMD_TICK) begin
            if (i_state.mode == kdsf_pkg::MODE_DRAG) begin
                o_state.speed_x = tick_sx;
                o_state.speed_y = tick_sy;
                o_state.drag_x  = i_item.pos_x;
                o_state.drag_y  = i_item.pos_y;
            end else if (i_state.mode == kdsf_pkg::MODE_COAST) begin
                o_state.speed_x = dec_x;
                o_state.speed_y = dec_y;
                o_state.page_x  = i_state.page_x - {{15{dec_x[16]}}, dec_x};
                o_state.page_y  = i_state.page_y - {{15{dec_y[16]}}, dec_y};
                o_written       = 1'b1;
                if (dec_x == 17'sd0 && dec_y == 17'sd0) o_state.mode = kdsf_pkg::MODE_IDLE;
            end
        end else if (at_press) begin
            // pointer event at the stored press point drops back to idle
            o_state.mode = kdsf_pkg::MODE_IDLE;
        end else begin
            case (i_state.mode)
                kdsf_pkg::MODE_IDLE: begin
                    if (i_item.cmd == kdsf_pkg::CMD_PRESS && i_item.left_only) begin
                        o_state.mode    = kdsf_pkg::MODE_PRESSED;
                        o_state.press_x = i_item.pos_x;
                        o_state.press_y = i_item.pos_y;
                        o_state.grab_x  = i_state.page_x;
                        o_state.grab_y  = i_state.page_y;
                    end
                end
                kdsf_pkg::MODE_PRESSED: begin
                    if (i_item.cmd == kdsf_pkg::CMD_RELEASE) begin
                        o_consumed   = 1'b1;
                        o_state.mode = kdsf_pkg::MODE_IDLE;
                    end else if (i_item.cmd == kdsf_pkg::CMD_MOVE) begin
                        o_consumed     = 1'b1;
                        o_state.mode   = kdsf_pkg::MODE_DRAG;
                        o_state.drag_x = i_item.pos_x;
                        o_state.drag_y = i_item.pos_y;
                    end
                end
                kdsf_pkg::MODE_DRAG: begin
                    if (i_item.cmd == kdsf_pkg::CMD_MOVE) begin
                        o_consumed     = 1'b1;
                        o_state.page_x = i_state.grab_x - {{15{trav_x[16]}}, trav_x};
                        o_state.page_y = i_state.grab_y - {{15{trav_y[16]}}, trav_y};
                        o_written      = 1'b1;
                    end else if (i_item.cmd == kdsf_pkg::CMD_RELEASE) begin
                        o_consumed   = 1'b1;
                        o_state.mode = kdsf_pkg::MODE_COAST;
                    end
                end
                kdsf_pkg::MODE_COAST: begin
                    if (i_item.cmd == kdsf_pkg::CMD_PRESS) begin
                        o_consumed      = 1'b1;
                        o_state.grab_x  = i_state.page_x;
                        o_state.grab_y  = i_state.page_y;
                        o_state.mode    = kdsf_pkg::MODE_STOP;
                        o_state.speed_x = '0;
                        o_state.speed_y = '0;
                    end else if (i_item.cmd == kdsf_pkg::CMD_RELEASE) begin
                        o_consumed      = 1'b1;
                        o_state.mode    = kdsf_pkg::MODE_IDLE;
                        o_state.speed_x = '0;
                        o_state.speed_y = '0;
                    end
                end
                kdsf_pkg::MODE_STOP: begin
                    if (i_item.cmd == kdsf_pkg::CMD_RELEASE) begin
                        o_consumed   = 1'b1;
                        o_state.mode = kdsf_pkg::MODE_IDLE;
                    end else if (i_item.cmd == kdsf_pkg::CMD_MOVE) begin
                        // back to dragging, scroll restored to the grab point
                        o_state.mode   = kdsf_pkg::MODE_DRAG;
                        o_state.page_x = i_state.grab_x;
                        o_state.page_y = i_state.grab_y;
                        o_written      = 1'b1;
                    end
                end
                default: begin
                    o_state.mode = kdsf_pkg::MODE_IDLE;
                end
            endcase
        end
    end

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the kinetic drag-scroll controller: directed table, random gestures.
module testbench;

    // one result beat, as carried on o_m_tdata
    typedef struct packed {
        logic        consumed;
        logic        written;
        logic [31:0] view_x;
        logic [31:0] view_y;
        logic [2:0]  mode;
    } view_t;

    // one row of the directed table; typed rows carry their own expected beat
    typedef struct {
        kdsf_pkg::t_cmd cmd;
        logic [15:0]    px;
        logic [15:0]    py;
        logic           left_btn;
        bit             typed;
        view_t          want;
    } step_row_t;

    localparam view_t NO_VIEW = '0;
    localparam int    N_STEPS = 25;
    localparam int    N_PHASES = 6;
    localparam int    PHASE_BEATS = 310;
    localparam int    DRAIN_CYCLES = 8;
    localparam int    LONG_HOLD = 300;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n;
    logic                                 i_s_tvalid;
    logic                                 o_s_tready;
    logic [kdsf_pkg::IN_DATA_W-1:0]       i_s_tdata;
    logic [kdsf_pkg::CMD_W-1:0]           i_s_tuser;
    logic                                 o_m_tvalid;
    logic                                 i_m_tready;
    logic [kdsf_pkg::OUT_DATA_W-1:0]      o_m_tdata;
    logic                                 psel;
    logic                                 penable;
    logic                                 pwrite;
    logic [kdsf_pkg::APB_ADDR_W-1:0]      paddr;
    logic [kdsf_pkg::APB_DATA_W-1:0]      pwdata;
    logic [kdsf_pkg::APB_DATA_W-1:0]      prdata;
    logic                                 pready;

    kinetic_drag_scroll_fsm dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Scroll tracker: own copy of the controller state and registers.
    // ------------------------------------------------------------------
    logic [7:0]         cfg_decel = kdsf_pkg::DECEL_STEP_RST;
    logic [14:0]        cfg_limit = kdsf_pkg::SPEED_LIMIT_RST;
    logic [2:0]         trk_mode = kdsf_pkg::CODE_IDLE;
    logic signed [15:0] trk_press_x = '0, trk_press_y = '0;
    logic [31:0]        trk_grab_x = '0, trk_grab_y = '0;
    logic signed [15:0] trk_drag_x = '0, trk_drag_y = '0;
    logic signed [16:0] trk_speed_x = '0, trk_speed_y = '0;
    logic [31:0]        trk_page_x = '0, trk_page_y = '0;

    view_t pending_views[$];   // expected result beats, oldest first
    int    mismatches = 0;
    int    beats_sent = 0;
    int    beats_checked = 0;
    bit    src_idle_on = 1'b1;
    bit    snk_idle_on = 1'b1;
    bit    hold_req = 1'b0;

    // clamp to +-limit, then pull toward zero by the decel step
    function automatic int shrink_speed(input int v);
        int lim;
        int step;
        lim = int'(cfg_limit);
        step = int'(cfg_decel);
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        if (v > 0) begin
            v = v - step;
            if (v < 0) v = 0;
        end else if (v < 0) begin
            v = v + step;
            if (v > 0) v = 0;
        end
        return v;
    endfunction

    task automatic track_pointer(input kdsf_pkg::t_cmd c, input logic [15:0] x,
                                 input logic [15:0] y, input logic left_btn,
                                 output view_t v);
        int px;
        int py;
        int sx;
        int sy;
        logic consumed;
        logic written;
        px = int'($signed(x));
        py = int'($signed(y));
        consumed = 1'b0;
        written = 1'b0;
        if (c == kdsf_pkg::CMD_TICK) begin
            // ticks skip the press-point check
            if (trk_mode == kdsf_pkg::CODE_DRAG) begin
                trk_speed_x = 17'(px - int'(trk_drag_x));
                trk_speed_y = 17'(py - int'(trk_drag_y));
                trk_drag_x = x;
                trk_drag_y = y;
            end else if (trk_mode == kdsf_pkg::CODE_COAST) begin
                sx = shrink_speed(trk_speed_x);
                sy = shrink_speed(trk_speed_y);
                trk_speed_x = 17'(sx);
                trk_speed_y = 17'(sy);
                trk_page_x = trk_page_x - 32'(sx);
                trk_page_y = trk_page_y - 32'(sy);
                written = 1'b1;
                if (sx == 0 && sy == 0) trk_mode = kdsf_pkg::CODE_IDLE;
            end
        end else if (x == trk_press_x && y == trk_press_y) begin
            // any non-tick event at the stored press point drops back to idle
            trk_mode = kdsf_pkg::CODE_IDLE;
        end else begin
            case (trk_mode)
                kdsf_pkg::CODE_IDLE: begin
                    if (c == kdsf_pkg::CMD_PRESS && left_btn) begin
                        trk_mode = kdsf_pkg::CODE_PRESSED;
                        trk_press_x = x;
                        trk_press_y = y;
                        trk_grab_x = trk_page_x;
                        trk_grab_y = trk_page_y;
                    end
                end
                kdsf_pkg::CODE_PRESSED: begin
                    if (c == kdsf_pkg::CMD_RELEASE) begin
                        consumed = 1'b1;
                        trk_mode = kdsf_pkg::CODE_IDLE;
                    end else if (c == kdsf_pkg::CMD_MOVE) begin
                        consumed = 1'b1;
                        trk_mode = kdsf_pkg::CODE_DRAG;
                        trk_drag_x = x;
                        trk_drag_y = y;
                    end
                end
                kdsf_pkg::CODE_DRAG: begin
                    if (c == kdsf_pkg::CMD_MOVE) begin
                        consumed = 1'b1;
                        trk_page_x = trk_grab_x - 32'(px - int'(trk_press_x));
                        trk_page_y = trk_grab_y - 32'(py - int'(trk_press_y));
                        written = 1'b1;
                    end else if (c == kdsf_pkg::CMD_RELEASE) begin
                        consumed = 1'b1;
                        trk_mode = kdsf_pkg::CODE_COAST;
                    end
                end
                kdsf_pkg::CODE_COAST: begin
                    if (c == kdsf_pkg::CMD_PRESS) begin
                        consumed = 1'b1;
                        trk_grab_x = trk_page_x;
                        trk_grab_y = trk_page_y;
                        trk_mode = kdsf_pkg::CODE_STOP;
                        trk_speed_x = '0;
                        trk_speed_y = '0;
                    end else if (c == kdsf_pkg::CMD_RELEASE) begin
                        consumed = 1'b1;
                        trk_mode = kdsf_pkg::CODE_IDLE;
                        trk_speed_x = '0;
                        trk_speed_y = '0;
                    end
                end
                kdsf_pkg::CODE_STOP: begin
                    if (c == kdsf_pkg::CMD_RELEASE) begin
                        consumed = 1'b1;
                        trk_mode = kdsf_pkg::CODE_IDLE;
                    end else if (c == kdsf_pkg::CMD_MOVE) begin
                        // back to dragging, scroll snaps to the grab offset
                        trk_mode = kdsf_pkg::CODE_DRAG;
                        trk_page_x = trk_grab_x;
                        trk_page_y = trk_grab_y;
                        written = 1'b1;
                    end
                end
                default: trk_mode = kdsf_pkg::CODE_IDLE;
            endcase
        end
        v.consumed = consumed;
        v.written = written;
        v.view_x = trk_page_x;
        v.view_y = trk_page_y;
        v.mode = trk_mode;
    endtask

    // ------------------------------------------------------------------
    // Directed table. Typed rows are readable at a glance; the rest go
    // through the tracker.
    // ------------------------------------------------------------------
    step_row_t dir_steps [N_STEPS] = '{
        // tick while idle is ignored
        '{kdsf_pkg::CMD_TICK,    16'sd5,      16'sd5,      1'b0, 1'b1,
          '{1'b0, 1'b0, 32'd0, 32'd0, kdsf_pkg::CODE_IDLE}},
        // press at the reset press point (0,0) counts as an event at the press point
        '{kdsf_pkg::CMD_PRESS,   16'sd0,      16'sd0,      1'b1, 1'b1,
          '{1'b0, 1'b0, 32'd0, 32'd0, kdsf_pkg::CODE_IDLE}},
        // press without left-only is ignored
        '{kdsf_pkg::CMD_PRESS,   16'sd100,   -16'sd50,     1'b0, 1'b1,
          '{1'b0, 1'b0, 32'd0, 32'd0, kdsf_pkg::CODE_IDLE}},
        '{kdsf_pkg::CMD_PRESS,   16'sd100,   -16'sd50,     1'b1, 1'b1,
          '{1'b0, 1'b0, 32'd0, 32'd0, kdsf_pkg::CODE_PRESSED}},
        '{kdsf_pkg::CMD_MOVE,    16'sd110,   -16'sd40,     1'b1, 1'b1,
          '{1'b1, 1'b0, 32'd0, 32'd0, kdsf_pkg::CODE_DRAG}},
        // drag to the coordinate extremes
        '{kdsf_pkg::CMD_MOVE,    16'sd32767, -16'sd32768,  1'b0, 1'b0, NO_VIEW},
        '{kdsf_pkg::CMD_TICK,    16'sd32767, -16'sd32768,  1'b1, 1'b0, NO_VIEW},
        // full-scale speed sample in both directions
        '{kdsf_pkg::CMD_TICK,   -16'sd32768,  16'sd32767,  1'b1, 1'b0, NO_VIEW},
        '{kdsf_pkg::CMD_RELEASE, 16'sd1,      16'sd1,      1'b0, 1'b0, NO_VIEW},
        '{kdsf_pkg::CMD_TICK,    16'sd0,      16'sd0,      1'b0, 1'b0, NO_VIEW},
        // press while coasting stops it, tick in stopped is ignored
        '{kdsf_pkg::CMD_PRESS,   16'sd2,      16'sd2,      1'b1, 1'b0, NO_VIEW},
        '{kdsf_pkg::CMD_TICK,    16'sd0,      16'sd0,      1'b0, 1'b0, NO_VIEW},
        // move from stopped snaps back to the grab offset
        '{kdsf_pkg::CMD_MOVE,    16'sd3,      16'sd3,      1'b1, 1'b0, NO_VIEW},
        '{kdsf_pkg::CMD_MOVE,    16'sd100,   -16'sd50,     1'b1, 1'b0, NO_VIEW},
        '{kdsf_pkg::CMD_RELEASE, 16'sd7,      16'sd7,      1'b0, 1'b0, NO_VIEW},
        '{kdsf_pkg::CMD_PRESS,  -16'sd32768,  16'sd32767,  1'b1, 1'b0, NO_VIEW},
        '{kdsf_pkg::CMD_PRESS,   16'sd5,      16'sd5,      1'b1, 1'b0, NO_VIEW},
        '{kdsf_pkg::CMD_RELEASE, 16'sd5,      16'sd5,      1'b1, 1'b0, NO_VIEW},
        '{kdsf_pkg::CMD_PRESS,  -16'sd1,     -16'sd1,      1'b1, 1'b0, NO_VIEW},
        '{kdsf_pkg::CMD_MOVE,    16'sd0,     -16'sd1,      1'b1, 1'b0, NO_VIEW},
        '{kdsf_pkg::CMD_PRESS,   16'sd4,      16'sd4,      1'b1, 1'b0, NO_VIEW},
        '{kdsf_pkg::CMD_TICK,    16'sd2,     -16'sd1,      1'b1, 1'b0, NO_VIEW},
        '{kdsf_pkg::CMD_RELEASE, 16'sd9,      16'sd9,      1'b0, 1'b0, NO_VIEW},
        // coast runs down to zero speed and goes idle
        '{kdsf_pkg::CMD_TICK,    16'sd0,      16'sd0,      1'b0, 1'b0, NO_VIEW},
        '{kdsf_pkg::CMD_TICK,    16'sd0,      16'sd0,      1'b0, 1'b0, NO_VIEW}
    };

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch on %s at result beat %0d: got %h, want %h",
                 what, beats_checked, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // one beat: optional idle burst, offer, wait for the handshake, then predict
    task automatic push_event(input kdsf_pkg::t_cmd c, input logic [15:0] x,
                              input logic [15:0] y, input logic left_btn,
                              input bit typed, input view_t want);
        view_t v;
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {7'b0, left_btn, y, x};
        i_s_tuser <= c;
        do @(posedge i_clk); while (!o_s_tready);
        track_pointer(c, x, y, left_btn, v);
        pending_views.push_back(typed ? want : v);
        beats_sent++;
    endtask

    function automatic logic [15:0] pick_coord();
        if ($urandom_range(0, 3) == 0) return 16'($urandom);
        return 16'($urandom_range(0, 600)) - 16'd300;
    endfunction

    function automatic logic [15:0] nudge(input logic [15:0] c);
        return c + 16'($urandom_range(0, 80)) - 16'd40;
    endfunction

    // press, drag with sampling ticks, release, coast, then maybe stop or cancel
    task automatic drag_gesture();
        logic [15:0] x;
        logic [15:0] y;
        int n;
        x = pick_coord();
        y = pick_coord();
        push_event(kdsf_pkg::CMD_PRESS, x, y, ($urandom_range(0, 9) != 0), 1'b0, NO_VIEW);
        n = $urandom_range(0, 6);
        repeat (n) begin
            x = nudge(x);
            y = nudge(y);
            push_event(kdsf_pkg::CMD_MOVE, x, y, 1'($urandom_range(0, 1)), 1'b0, NO_VIEW);
            if ($urandom_range(0, 1) == 1)
                push_event(kdsf_pkg::CMD_TICK, nudge(x), nudge(y), 1'b1, 1'b0, NO_VIEW);
        end
        push_event(kdsf_pkg::CMD_RELEASE, nudge(x), nudge(y), 1'($urandom_range(0, 1)),
                   1'b0, NO_VIEW);
        n = $urandom_range(0, 24);
        repeat (n)
            push_event(kdsf_pkg::CMD_TICK, pick_coord(), pick_coord(),
                       1'($urandom_range(0, 1)), 1'b0, NO_VIEW);
        case ($urandom_range(0, 3))
            0: begin
                push_event(kdsf_pkg::CMD_PRESS, pick_coord(), pick_coord(), 1'b1,
                           1'b0, NO_VIEW);
                if ($urandom_range(0, 1) == 1)
                    push_event(kdsf_pkg::CMD_MOVE, pick_coord(), pick_coord(), 1'b1,
                               1'b0, NO_VIEW);
                push_event(kdsf_pkg::CMD_RELEASE, pick_coord(), pick_coord(), 1'b0,
                           1'b0, NO_VIEW);
            end
            1: push_event(kdsf_pkg::CMD_RELEASE, pick_coord(), pick_coord(), 1'b0,
                          1'b0, NO_VIEW);
            default: ;
        endcase
    endtask

    // random command; a quarter of them land on the stored press point
    task automatic stray_event();
        kdsf_pkg::t_cmd c;
        logic [15:0] x;
        logic [15:0] y;
        c = kdsf_pkg::t_cmd'($urandom_range(0, 3));
        if ($urandom_range(0, 3) == 0) begin
            x = trk_press_x;
            y = trk_press_y;
        end else begin
            x = pick_coord();
            y = pick_coord();
        end
        push_event(c, x, y, 1'($urandom_range(0, 1)), 1'b0, NO_VIEW);
    endtask

    // stop offering and let the pipeline run dry before touching registers
    task automatic quiesce();
        i_s_tvalid <= 1'b0;
        while (pending_views.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle (pready is tied high)
    task automatic set_register(input logic idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == kdsf_pkg::REG_DECEL_STEP) cfg_decel = val[7:0];
        else cfg_limit = val[14:0];
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [7:0]  ph_decel [N_PHASES] = '{8'd255, 8'd0, 8'd3, 8'd255, 8'd1, 8'd0};
        logic [14:0] ph_limit [N_PHASES] = '{15'd0, 15'd32767, 15'd100, 15'd32767,
                                             15'd5, 15'd64};
        int target;
        i_rst_n <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata <= '0;
        i_s_tuser <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at the reset register values
        foreach (dir_steps[k])
            push_event(dir_steps[k].cmd, dir_steps[k].px, dir_steps[k].py,
                       dir_steps[k].left_btn, dir_steps[k].typed, dir_steps[k].want);

        // random phases, one register setting each; the last one is random
        for (int ph = 0; ph < N_PHASES; ph++) begin
            quiesce();
            if (ph == N_PHASES - 1) begin
                ph_decel[ph] = 8'($urandom);
                ph_limit[ph] = 15'($urandom);
                src_idle_on = 1'b0;
                snk_idle_on = 1'b0;
            end
            set_register(kdsf_pkg::REG_DECEL_STEP, {24'b0, ph_decel[ph]});
            set_register(kdsf_pkg::REG_SPEED_LIMIT, {17'b0, ph_limit[ph]});
            // long result-side hold while beats keep coming: pipeline fills up
            if (ph == 1) hold_req = 1'b1;
            target = beats_sent + PHASE_BEATS;
            while (beats_sent < target) begin
                if ($urandom_range(0, 4) == 0) stray_event();
                else drag_gesture();
            end
        end

        i_s_tvalid <= 1'b0;
        while (pending_views.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random backpressure bursts plus one long hold
    // ------------------------------------------------------------------
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_m_tready <= 1'b0;
                stall_left = LONG_HOLD - 1;
            end else if (stall_left > 0) begin
                stall_left--;
            end else if (snk_idle_on && $urandom_range(0, 4) == 0) begin
                i_m_tready <= 1'b0;
                stall_left = $urandom_range(0, 12);
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // compare each result beat against the oldest expectation
    always @(posedge i_clk) begin : result_check
        view_t got;
        view_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.consumed = o_m_tdata[0];
            got.written = o_m_tdata[1];
            got.view_x = o_m_tdata[33:2];
            got.view_y = o_m_tdata[65:34];
            got.mode = o_m_tdata[68:66];
            if (pending_views.size() == 0) begin
                flag_mismatch("unexpected beat", {29'b0, got.mode}, '0);
            end else begin
                want = pending_views.pop_front();
                if (got.consumed !== want.consumed)
                    flag_mismatch("consumed", {31'b0, got.consumed}, {31'b0, want.consumed});
                if (got.written !== want.written)
                    flag_mismatch("scroll_written", {31'b0, got.written}, {31'b0, want.written});
                if (got.view_x !== want.view_x)
                    flag_mismatch("view_x", got.view_x, want.view_x);
                if (got.view_y !== want.view_y)
                    flag_mismatch("view_y", got.view_y, want.view_y);
                if (got.mode !== want.mode)
                    flag_mismatch("mode_now", {29'b0, got.mode}, {29'b0, want.mode});
            end
            beats_checked++;
        end
    end

    // hard stop well beyond the slowest legal run
    initial begin : watchdog
        #5000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* sim.f */
rtl/kdsf_pkg.sv
rtl/kdsf_decay.sv
rtl/kdsf_cfg.sv
rtl/kdsf_core.sv
rtl/kinetic_drag_scroll_fsm.sv
tb/testbench.sv
